[rtl/pctbl_pkg.sv]
// Shared types and constants for the per-client token bucket limiter.
`timescale 1ns / 1ps
`default_nettype none
package pctbl_pkg;
    localparam int DEF_ENTRIES = 64;
    localparam int TIME_W = 48;
    localparam int TOK_W = 26;
    localparam int CNT_W = 7;
    localparam logic [9:0] MILLI = 10'd1000;

    localparam logic [1:0] REG_RATE = 2'd0;
    localparam logic [1:0] REG_BURST = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    typedef struct packed {
        logic start_req;
        logic scan_step;
        logic finish;
    } pctbl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } pctbl_stat_t;
endpackage
`default_nettype wire

[rtl/pctbl_ctrl.sv]
// Controller state machine that sequences the table scan of one item.
`timescale 1ns / 1ps
`default_nettype none
module pctbl_ctrl
    import pctbl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire pctbl_stat_t stat,
    output pctbl_cmd_t       cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.start_req = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

[rtl/pctbl_dp.sv]
// Datapath: bucket table, one-entry-per-cycle scan, refill arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module pctbl_dp
    import pctbl_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pctbl_cmd_t         cmd,
    output pctbl_stat_t             stat,
    input  wire logic               opcode,
    input  wire logic [31:0]        client_addr,
    input  wire logic [TIME_W-1:0]  now_ms,
    input  wire logic [15:0]        rate,
    input  wire logic [15:0]        burst,
    input  wire logic [31:0]        interval,
    input  wire logic [31:0]        timeout,
    output logic                    allowed,
    output logic                    new_entry,
    output logic                    table_full,
    output logic [CNT_W-1:0]        evicted_count,
    output logic [31:0]             limited_total
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        key_mem [ENTRIES];
    logic [TOK_W-1:0]   tok_mem [ENTRIES];
    logic [TIME_W-1:0]  last_mem [ENTRIES];

    logic              op_reg;
    logic [31:0]       key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [IW-1:0]     idx_reg;
    logic              hit_reg, free_reg, sweep_reg;
    logic [IW-1:0]     hit_idx_reg, free_idx_reg;
    logic [CW-1:0]     evict_reg;
    logic [31:0]       denied_reg;
    logic [TIME_W-1:0] last_sweep_reg;
    logic              armed_reg;
    logic [31:0]       rd_key_reg;
    logic [TOK_W-1:0]  rd_tok_reg;
    logic [TIME_W-1:0] rd_last_reg;
    logic              rd_valid_reg, rd_live_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic [IW-1:0]     idx_next;
    logic              ph_reg;
    logic              sweep_due;
    logic [TIME_W-1:0] elapsed;
    logic [TOK_W+15:0] add;
    logic              add_big;
    logic [TOK_W-1:0]  cap, tsum, trefill;
    logic [TOK_W:0]    tsum_w;
    logic              alw_reg, new_reg, full_reg;
    logic [CNT_W-1:0]  evc_reg;

    assign stat.scan_last = ph_reg;
    assign idx_next = idx_reg + IW'(1);
    assign sweep_due = opcode && armed_reg &&
                       ((now_ms - last_sweep_reg) >= TIME_W'(interval));

    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[idx_reg];
        rd_tok_reg <= tok_mem[hit_idx_reg];
        rd_last_reg <= last_mem[sweep_reg ? idx_reg : hit_idx_reg];
        rd_idx_reg <= idx_reg;
    end

    // Refill of the hit entry, evaluated after the scan. An elapsed time at or above
    // 2^26 ms always reaches the cap unless the rate is zero.
    assign elapsed = now_reg - rd_last_reg;
    assign cap = TOK_W'(burst) * TOK_W'(MILLI);
    assign add = elapsed[TOK_W-1:0] * rate;
    assign add_big = ((rate != '0) && (elapsed[TIME_W-1:TOK_W] != '0)) ||
                     (add >= (TOK_W+16)'(cap));
    assign tsum_w = {1'b0, rd_tok_reg} + (TOK_W+1)'(add[TOK_W-1:0]);
    assign tsum = (tsum_w > {1'b0, cap}) ? cap : tsum_w[TOK_W-1:0];
    assign trefill = (elapsed == '0) ? rd_tok_reg :
                     add_big ? cap : tsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            denied_reg <= '0;
            last_sweep_reg <= '0;
            armed_reg <= 1'b0;
            ph_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.scan_step && !ph_reg;
            if (cmd.start_req)
            begin
                op_reg <= opcode;
                key_reg <= client_addr;
                now_reg <= now_ms;
                idx_reg <= '0;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
                hit_idx_reg <= '0;
                free_idx_reg <= '0;
                evict_reg <= '0;
                ph_reg <= 1'b0;
                sweep_reg <= sweep_due;
                if (opcode && !armed_reg)
                begin
                    armed_reg <= 1'b1;
                    last_sweep_reg <= now_ms;
                end
                else if (sweep_due)
                    last_sweep_reg <= now_ms;
            end
            if (cmd.scan_step)
            begin
                rd_valid_reg <= valid_reg[idx_reg];
                if (rd_live_reg)
                begin
                    if (!sweep_reg)
                    begin
                        if (rd_valid_reg && !hit_reg && rd_key_reg == key_reg)
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                        end
                        if (!rd_valid_reg && !free_reg)
                        begin
                            free_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                    else if (rd_valid_reg && (now_reg - rd_last_reg) > TIME_W'(timeout))
                    begin
                        valid_reg[rd_idx_reg] <= 1'b0;
                        evict_reg <= evict_reg + CW'(1);
                    end
                end
                if (!ph_reg)
                begin
                    if (32'(idx_reg) == ENTRIES - 1)
                        ph_reg <= 1'b1;
                    else
                        idx_reg <= idx_next;
                end
            end
            if (cmd.finish)
            begin
                alw_reg <= !op_reg && (!hit_reg || (trefill >= TOK_W'(MILLI)));
                new_reg <= !op_reg && !hit_reg && free_reg;
                full_reg <= !op_reg && !hit_reg && !free_reg;
                if (op_reg && sweep_reg)
                    evc_reg <= (32'(evict_reg) > 127) ? 7'd127 : CNT_W'(evict_reg);
                else
                    evc_reg <= '0;
                if (!op_reg && !hit_reg && free_reg)
                    valid_reg[free_idx_reg] <= 1'b1;
                if (!op_reg && hit_reg && (trefill < TOK_W'(MILLI)))
                    denied_reg <= denied_reg + 32'd1;
            end
        end
    end

    // Table write at item end.
    always_ff @(posedge clk)
    begin
        if (cmd.finish && !op_reg)
        begin
            if (hit_reg)
            begin
                last_mem[hit_idx_reg] <= now_reg;
                tok_mem[hit_idx_reg] <= (trefill >= TOK_W'(MILLI)) ?
                                        trefill - TOK_W'(MILLI) : trefill;
            end
            else if (free_reg)
            begin
                key_mem[free_idx_reg] <= key_reg;
                last_mem[free_idx_reg] <= now_reg;
                tok_mem[free_idx_reg] <= (burst == '0) ? '0 :
                    TOK_W'(burst - 16'd1) * TOK_W'(MILLI);
            end
        end
    end

    assign allowed = alw_reg;
    assign new_entry = new_reg;
    assign table_full = full_reg;
    assign evicted_count = evc_reg;
    assign limited_total = denied_reg;
endmodule
`default_nettype wire

[rtl/pctbl_regs.sv]
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module pctbl_regs
    import pctbl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic [15:0]      rate,
    output logic [15:0]      burst,
    output logic [31:0]      interval,
    output logic [31:0]      timeout
);
    logic [15:0] rate_reg, burst_reg;
    logic [31:0] interval_reg, timeout_reg;
    logic wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 16'd10;
            burst_reg <= 16'd20;
            interval_reg <= 32'd60000;
            timeout_reg <= 32'd120000;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_RATE:     rate_reg <= pwdata[15:0];
                REG_BURST:    burst_reg <= pwdata[15:0];
                REG_INTERVAL: interval_reg <= pwdata;
                REG_TIMEOUT:  timeout_reg <= pwdata;
                default:      rate_reg <= rate_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RATE:     prdata = {16'd0, rate_reg};
            REG_BURST:    prdata = {16'd0, burst_reg};
            REG_INTERVAL: prdata = interval_reg;
            REG_TIMEOUT:  prdata = timeout_reg;
            default:      prdata = '0;
        endcase
    end

    assign rate = rate_reg;
    assign burst = burst_reg;
    assign interval = interval_reg;
    assign timeout = timeout_reg;
endmodule
`default_nettype wire

[rtl/per_client_token_bucket_limiter.sv]
// Top level of the per-client token bucket limiter.
// The scan reads one table entry per cycle from the key memory, and from the time memory during a sweep.
// One item is in flight at a time: a new item is accepted only once the last one's result is produced,
// and a stalled result holds off the next item.
// Reset clears all valid bits, the denial counter and the sweep timer; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module per_client_token_bucket_limiter
    import pctbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              opcode,
    input  wire logic [31:0]       client_addr,
    input  wire logic [TIME_W-1:0] now_ms,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   allowed,
    output logic                   new_entry,
    output logic                   table_full,
    output logic [CNT_W-1:0]       evicted_count,
    output logic [31:0]            limited_total,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    pctbl_cmd_t cmd;
    pctbl_stat_t stat;
    logic [15:0] rate, burst;
    logic [31:0] interval, timeout;

    assign pready = 1'b1;

    pctbl_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .rate(rate), .burst(burst),
        .interval(interval), .timeout(timeout)
    );

    pctbl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    pctbl_dp #(.ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .opcode(opcode),
        .client_addr(client_addr), .now_ms(now_ms), .rate(rate), .burst(burst),
        .interval(interval), .timeout(timeout), .allowed(allowed),
        .new_entry(new_entry), .table_full(table_full),
        .evicted_count(evicted_count), .limited_total(limited_total)
    );
endmodule
`default_nettype wire

[rtl/pctbl_checker.sv]
// Port-level checker for the limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pctbl_checker
    import pctbl_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic             allowed,
    input wire logic             new_entry,
    input wire logic             table_full,
    input wire logic [CNT_W-1:0] evicted_count,
    input wire logic [31:0]      limited_total
);
    a_new_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_entry |-> allowed && !table_full)
        else $error("new entry not allowed");
    a_full_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> allowed && !new_entry)
        else $error("full table result wrong");
    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_count != '0 |-> !allowed)
        else $error("sweep result allowed");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(limited_total))
        else $error("stalled item changed");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted");
endmodule

bind per_client_token_bucket_limiter pctbl_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .allowed(allowed),
    .new_entry(new_entry), .table_full(table_full),
    .evicted_count(evicted_count), .limited_total(limited_total)
);
`default_nettype wire

[tb/per_client_token_bucket_limiter_tb.sv]
// Self-checking testbench for the per-client token bucket limiter.
`timescale 1ns / 1ps
module per_client_token_bucket_limiter_tb;
    import pctbl_pkg::*;

    localparam int ENTRIES = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int POOL_N = 72;
    localparam logic OP_REQ = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    typedef struct {
        logic op;
        logic [31:0] key;
        logic [TIME_W-1:0] t;
    } req_item_t;

    typedef struct {
        logic allowed;
        logic new_entry;
        logic table_full;
        logic [CNT_W-1:0] evicted;
        logic [31:0] limited;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic opcode = 1'b0;
    logic [31:0] client_addr = '0;
    logic [TIME_W-1:0] now_ms = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic allowed;
    logic new_entry;
    logic table_full;
    logic [CNT_W-1:0] evicted_count;
    logic [31:0] limited_total;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    per_client_token_bucket_limiter uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .client_addr(client_addr), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .allowed(allowed), .new_entry(new_entry), .table_full(table_full),
        .evicted_count(evicted_count), .limited_total(limited_total),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    req_item_t pending_items[$];
    verdict_t expected_verdicts[$];
    int errors = 0;
    int items_sent = 0;
    int verdicts_seen = 0;
    int denials_seen = 0;
    int evictions_seen = 0;
    int full_seen = 0;

    // Predictor state.
    logic bkt_valid[ENTRIES];
    logic [31:0] bkt_key[ENTRIES];
    logic [TOK_W-1:0] bkt_tokens[ENTRIES];
    logic [TIME_W-1:0] bkt_last[ENTRIES];
    logic [31:0] denied_count;
    logic [TIME_W-1:0] sweep_time;
    logic sweep_armed;
    logic [15:0] cfg_rate = 16'd10;
    logic [15:0] cfg_burst = 16'd20;
    logic [31:0] cfg_interval = 32'd60000;
    logic [31:0] cfg_timeout = 32'd120000;

    logic [31:0] key_pool[POOL_N];
    logic [TIME_W-1:0] clock_ms = '0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic verdict_t admit(req_item_t it);
        verdict_t v;
        int hit;
        int slot;
        int cnt;
        logic [31:0] cap;
        logic [31:0] tok;
        logic [TIME_W-1:0] dt;
        logic [63:0] add;
        v = '{1'b0, 1'b0, 1'b0, '0, '0};
        hit = -1;
        slot = -1;
        cnt = 0;
        cap = cfg_burst * 32'd1000;
        if (it.op == OP_REQ)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (bkt_valid[i])
                begin
                    if (hit < 0 && bkt_key[i] == it.key)
                        hit = i;
                end
                else if (slot < 0)
                    slot = i;
            end
            if (hit < 0)
            begin
                v.allowed = 1'b1;
                if (slot < 0)
                    v.table_full = 1'b1;
                else
                begin
                    bkt_valid[slot] = 1'b1;
                    bkt_key[slot] = it.key;
                    bkt_tokens[slot] = (cfg_burst != 0) ? (cfg_burst - 1) * 1000 : 0;
                    bkt_last[slot] = it.t;
                    v.new_entry = 1'b1;
                end
            end
            else
            begin
                tok = bkt_tokens[hit];
                dt = it.t - bkt_last[hit];
                if (dt != 0)
                begin
                    add = 64'(dt) * 64'(cfg_rate);
                    if (add >= 64'(cap))
                        tok = cap;
                    else
                    begin
                        tok = tok + add[31:0];
                        if (tok > cap)
                            tok = cap;
                    end
                end
                bkt_last[hit] = it.t;
                if (tok >= 1000)
                begin
                    tok = tok - 1000;
                    v.allowed = 1'b1;
                end
                else
                    denied_count = denied_count + 1;
                bkt_tokens[hit] = tok[TOK_W-1:0];
            end
        end
        else if (!sweep_armed)
        begin
            sweep_armed = 1'b1;
            sweep_time = it.t;
        end
        else if (TIME_W'(it.t - sweep_time) >= TIME_W'(cfg_interval))
        begin
            sweep_time = it.t;
            for (int i = 0; i < ENTRIES; i++)
            begin
                dt = it.t - bkt_last[i];
                if (bkt_valid[i] && dt > TIME_W'(cfg_timeout))
                begin
                    bkt_valid[i] = 1'b0;
                    cnt++;
                end
            end
            v.evicted = (cnt > 127) ? 7'd127 : CNT_W'(cnt);
        end
        v.limited = denied_count;
        return v;
    endfunction

    // Sender side: bursts of items separated by random gaps.
    logic took_item = 1'b0;
    int gap_left = 0;
    int burst_left = 0;

    always @(negedge clk)
    begin
        if (in_valid && !took_item)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
        end
        else if (pending_items.size() > 0)
        begin
            req_item_t it;
            it = pending_items.pop_front();
            opcode <= it.op;
            client_addr <= it.key;
            now_ms <= it.t;
            in_valid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver side: a 16-bit ready pattern, replaced with a new random one after each pass through it.
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0] pattern_pos = '0;

    always @(negedge clk)
    begin
        out_ready <= ready_pattern[pattern_pos];
        pattern_pos <= pattern_pos + 1;
        if (pattern_pos == 4'hF)
            ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    end

    int idle_cycles = 0;

    always @(posedge clk)
    begin
        verdict_t exp_v;
        took_item <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result item at %0t", $realtime);
            end
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (allowed !== exp_v.allowed || new_entry !== exp_v.new_entry ||
                    table_full !== exp_v.table_full || evicted_count !== exp_v.evicted ||
                    limited_total !== exp_v.limited)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch at %0t: exp a=%b n=%b f=%b e=%0d l=%0d, got a=%b n=%b f=%b e=%0d l=%0d",
                            $realtime, exp_v.allowed, exp_v.new_entry, exp_v.table_full,
                            exp_v.evicted, exp_v.limited, allowed, new_entry, table_full,
                            evicted_count, limited_total);
                end
            end
        end
        if (in_valid && in_ready)
        begin
            req_item_t it;
            it = '{opcode, client_addr, now_ms};
            exp_v = admit(it);
            if (exp_v.table_full)
                full_seen++;
            if (!exp_v.allowed && it.op == OP_REQ)
                denials_seen++;
            evictions_seen += exp_v.evicted;
            expected_verdicts.push_back(exp_v);
            items_sent++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_item(logic op, logic [31:0] key, logic [TIME_W-1:0] t);
        req_item_t it;
        it = '{op, key, t};
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RATE: cfg_rate = data[15:0];
            REG_BURST: cfg_burst = data[15:0];
            REG_INTERVAL: cfg_interval = data;
            REG_TIMEOUT: cfg_timeout = data;
            default: ;
        endcase
    endtask

    task automatic random_items(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                clock_ms = clock_ms + $urandom_range(0, 400);
            else if (r < 92)
                clock_ms = clock_ms + $urandom_range(0, 200000);
            else if (r < 96)
                clock_ms = {16'($urandom), 32'($urandom)};
            else
                clock_ms = clock_ms - $urandom_range(1, 5000);
            push_item(($urandom_range(0, 9) == 0) ? OP_SWEEP : OP_REQ,
                ($urandom_range(0, 19) == 0) ? 32'($urandom)
                                             : key_pool[$urandom_range(0, POOL_N - 1)],
                clock_ms);
        end
    endtask

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            bkt_valid[i] = 1'b0;
            bkt_key[i] = '0;
            bkt_tokens[i] = '0;
            bkt_last[i] = '0;
        end
        denied_count = '0;
        sweep_time = '0;
        sweep_armed = 1'b0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_N; i++)
            key_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_item(OP_SWEEP, 32'h0, 48'd0);
        push_item(OP_REQ, 32'h0, 48'd0);
        push_item(OP_REQ, 32'hFFFF_FFFF, 48'd1);
        for (int i = 0; i < 20; i++)
            push_item(OP_REQ, 32'h1234_5678, 48'd5);
        push_item(OP_SWEEP, 32'h0, 48'd100);
        push_item(OP_SWEEP, 32'hFFFF_FFFF, 48'd200000);
        push_item(OP_REQ, 32'h0, 48'hFFFF_FFFF_FFFF);
        push_item(OP_REQ, 32'h0, 48'd3);
        clock_ms = 48'd10;
        random_items(320);
        wait_idle();

        reg_write(REG_RATE, 32'd1);
        reg_write(REG_BURST, 32'd1);
        reg_write(REG_INTERVAL, 32'd1);
        reg_write(REG_TIMEOUT, 32'd1);
        random_items(300);
        wait_idle();

        reg_write(REG_RATE, 32'd65535);
        reg_write(REG_BURST, 32'd65535);
        reg_write(REG_INTERVAL, 32'hFFFF_FFFF);
        reg_write(REG_TIMEOUT, 32'hFFFF_FFFF);
        random_items(300);
        wait_idle();

        // Lowering the burst size leaves buckets above the new cap.
        reg_write(REG_BURST, 32'd2);
        reg_write(REG_RATE, 32'd3);
        reg_write(REG_INTERVAL, 32'd500);
        reg_write(REG_TIMEOUT, 32'd2000);
        random_items(300);
        wait_idle();

        for (int p = 0; p < 2; p++)
        begin
            reg_write(REG_RATE, $urandom_range(1, 65535));
            reg_write(REG_BURST, $urandom_range(1, 65535));
            reg_write(REG_INTERVAL, $urandom_range(1, 300000));
            reg_write(REG_TIMEOUT, $urandom_range(1, 300000));
            random_items(350);
            wait_idle();
        end

        repeat (100) @(posedge clk);
        $display("Checked %0d items and %0d results over six register settings.",
            items_sent, verdicts_seen);
        $display("Saw %0d denials, %0d evictions and %0d table-full requests.",
            denials_seen, evictions_seen, full_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
